[hw/rtl/scmt_pkg.sv]
package scmt_pkg;

    // line geometry
    localparam int MAX_LINE = 4096;
    localparam int POS_W    = 12;
    localparam int LEN_W    = POS_W + 1;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE - 1);

    // character codes
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    // quote kind codes
    localparam logic [1:0] QK_NONE   = 2'd0;
    localparam logic [1:0] QK_SINGLE = 2'd1;
    localparam logic [1:0] QK_DOUBLE = 2'd2;

    // record buffer geometry
    localparam int REC_SLOTS  = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [2:0] {
        KIND_WORD      = 3'd0,
        KIND_PIPE      = 3'd1,
        KIND_HEREDOC   = 3'd2,
        KIND_APPEND    = 3'd3,
        KIND_REDIR_IN  = 3'd4,
        KIND_REDIR_OUT = 3'd5,
        KIND_EOL       = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WORD = 2'd1,
        MODE_LT   = 2'd2,
        MODE_GT   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_line;
    } in_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [POS_W-1:0]  start_res;
        logic [LEN_W-1:0]  length;
        logic [1:0]        quote_kind;
        logic              run_last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]                     cnt;
        out_item_t [REC_SLOTS-1:0]      rec;
    } rec_batch_t;

endpackage

[hw/rtl/scmt_lexer.sv]
module scmt_lexer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_en,
    input  scmt_pkg::in_item_t   in_item,
    output scmt_pkg::rec_batch_t batch
);

    localparam int POS_W = scmt_pkg::POS_W;
    localparam int LEN_W = scmt_pkg::LEN_W;

    scmt_pkg::mode_t  mode_reg, mode_next, mode_mid;
    logic [POS_W-1:0] pos_reg, pos_next, pos_sat;
    logic [POS_W-1:0] tok_reg, tok_next, tok_mid;
    logic             sq_reg, sq_next, sq_mid;
    logic             dq_reg, dq_next, dq_mid;
    logic [1:0]       fq_reg, fq_next, fq_mid;

    logic [7:0] c;
    logic       eol;
    logic       is_sep, is_pipe, is_lt, is_gt, is_sq, is_dq;
    logic       pend, op_match, word_brk, run_idle;

    scmt_pkg::out_item_t [2:0] cand;
    logic [2:0]                cand_v;

    assign c   = in_item.ch;
    assign eol = in_item.end_of_line;

    assign is_sep  = (c == scmt_pkg::CH_SPACE) || (c == scmt_pkg::CH_TAB);
    assign is_pipe = (c == scmt_pkg::CH_PIPE);
    assign is_lt   = (c == scmt_pkg::CH_LT);
    assign is_gt   = (c == scmt_pkg::CH_GT);
    assign is_sq   = (c == scmt_pkg::CH_SQUOTE);
    assign is_dq   = (c == scmt_pkg::CH_DQUOTE);

    assign pend     = (mode_reg == scmt_pkg::MODE_LT) || (mode_reg == scmt_pkg::MODE_GT);
    assign op_match = ((mode_reg == scmt_pkg::MODE_LT) && is_lt)
                   || ((mode_reg == scmt_pkg::MODE_GT) && is_gt);
    assign word_brk = (mode_reg == scmt_pkg::MODE_WORD) && !sq_reg && !dq_reg
                   && (is_sep || is_pipe || is_lt || is_gt);
    assign run_idle = (mode_reg == scmt_pkg::MODE_IDLE) || (pend && !op_match) || word_brk;

    assign pos_sat = (pos_reg == scmt_pkg::POS_MAX) ? scmt_pkg::POS_MAX
                                                    : pos_reg + POS_W'(1);

    // next state
    always_comb begin
        mode_mid = mode_reg;
        tok_mid  = tok_reg;
        sq_mid   = sq_reg;
        dq_mid   = dq_reg;
        fq_mid   = fq_reg;
        case (mode_reg)
            scmt_pkg::MODE_WORD: begin
                if (is_sq && !dq_reg) begin
                    sq_mid = !sq_reg;
                    if (fq_reg == scmt_pkg::QK_NONE) begin
                        fq_mid = scmt_pkg::QK_SINGLE;
                    end
                end else if (is_dq && !sq_reg) begin
                    dq_mid = !dq_reg;
                    if (fq_reg == scmt_pkg::QK_NONE) begin
                        fq_mid = scmt_pkg::QK_DOUBLE;
                    end
                end
            end
            scmt_pkg::MODE_LT, scmt_pkg::MODE_GT: begin
                mode_mid = scmt_pkg::MODE_IDLE;
            end
            default: begin
            end
        endcase
        if (run_idle) begin
            mode_mid = scmt_pkg::MODE_IDLE;
            sq_mid   = 1'b0;
            dq_mid   = 1'b0;
            fq_mid   = scmt_pkg::QK_NONE;
            if (is_lt) begin
                mode_mid = scmt_pkg::MODE_LT;
                tok_mid  = pos_reg;
            end else if (is_gt) begin
                mode_mid = scmt_pkg::MODE_GT;
                tok_mid  = pos_reg;
            end else if (!is_sep && !is_pipe) begin
                // word starts, opening quote counts at once
                mode_mid = scmt_pkg::MODE_WORD;
                tok_mid  = pos_reg;
                sq_mid   = is_sq;
                dq_mid   = is_dq;
                fq_mid   = is_sq ? scmt_pkg::QK_SINGLE
                         : (is_dq ? scmt_pkg::QK_DOUBLE : scmt_pkg::QK_NONE);
            end
        end
        if (eol) begin
            mode_next = scmt_pkg::MODE_IDLE;
            pos_next  = '0;
            tok_next  = '0;
            sq_next   = 1'b0;
            dq_next   = 1'b0;
            fq_next   = scmt_pkg::QK_NONE;
        end else begin
            mode_next = mode_mid;
            pos_next  = pos_sat;
            tok_next  = tok_mid;
            sq_next   = sq_mid;
            dq_next   = dq_mid;
            fq_next   = fq_mid;
        end
    end

    // candidate records, in emission order
    always_comb begin
        cand   = '0;
        cand_v = '0;
        // pending operator or ended word
        if (pend) begin
            cand_v[0]          = 1'b1;
            cand[0].start_res  = tok_reg;
            if (op_match) begin
                cand[0].kind   = (mode_reg == scmt_pkg::MODE_LT) ? scmt_pkg::KIND_HEREDOC
                                                                 : scmt_pkg::KIND_APPEND;
                cand[0].length = LEN_W'(2);
            end else begin
                cand[0].kind   = (mode_reg == scmt_pkg::MODE_LT) ? scmt_pkg::KIND_REDIR_IN
                                                                 : scmt_pkg::KIND_REDIR_OUT;
                cand[0].length = LEN_W'(1);
            end
        end else if (word_brk) begin
            cand_v[0]           = 1'b1;
            cand[0].kind        = scmt_pkg::KIND_WORD;
            cand[0].start_res   = tok_reg;
            cand[0].length      = {1'b0, pos_reg} - {1'b0, tok_reg};
            cand[0].quote_kind  = fq_reg;
        end
        // pipe from idle, or flush at end of line (never both)
        if (run_idle && is_pipe) begin
            cand_v[1]         = 1'b1;
            cand[1].kind      = scmt_pkg::KIND_PIPE;
            cand[1].start_res = pos_reg;
            cand[1].length    = LEN_W'(1);
        end else if (eol) begin
            cand[1].start_res = tok_mid;
            cand[1].length    = LEN_W'(1);
            case (mode_mid)
                scmt_pkg::MODE_WORD: begin
                    cand_v[1]          = 1'b1;
                    cand[1].kind       = scmt_pkg::KIND_WORD;
                    cand[1].length     = {1'b0, pos_reg} + LEN_W'(1) - {1'b0, tok_mid};
                    cand[1].quote_kind = fq_mid;
                end
                scmt_pkg::MODE_LT: begin
                    cand_v[1]    = 1'b1;
                    cand[1].kind = scmt_pkg::KIND_REDIR_IN;
                end
                scmt_pkg::MODE_GT: begin
                    cand_v[1]    = 1'b1;
                    cand[1].kind = scmt_pkg::KIND_REDIR_OUT;
                end
                default: begin
                end
            endcase
        end
        if (eol) begin
            cand_v[2]         = 1'b1;
            cand[2].kind      = scmt_pkg::KIND_EOL;
            cand[2].start_res = pos_sat;
        end
    end

    // pack valid candidates to the front, mark the last one
    always_comb begin
        batch = '0;
        for (int i = 0; i < scmt_pkg::REC_SLOTS; i++) begin
            if (cand_v[i]) begin
                batch.rec[batch.cnt] = cand[i];
                batch.cnt            = batch.cnt + 2'd1;
            end
        end
        if (batch.cnt != 2'd0) begin
            batch.rec[batch.cnt - 2'd1].run_last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= scmt_pkg::MODE_IDLE;
            pos_reg  <= '0;
            tok_reg  <= '0;
            sq_reg   <= 1'b0;
            dq_reg   <= 1'b0;
            fq_reg   <= scmt_pkg::QK_NONE;
        end else if (in_en) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            tok_reg  <= tok_next;
            sq_reg   <= sq_next;
            dq_reg   <= dq_next;
            fq_reg   <= fq_next;
        end
    end

    a_tok_behind_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != scmt_pkg::MODE_IDLE) |-> (tok_reg <= pos_reg))
        else $error("token start ahead of position");

    a_quotes_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sq_reg && dq_reg) && (!(sq_reg || dq_reg) || (fq_reg != scmt_pkg::QK_NONE)))
        else $error("quote flags inconsistent");

    a_pending_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        ((mode_reg == scmt_pkg::MODE_LT) || (mode_reg == scmt_pkg::MODE_GT))
        |-> (!sq_reg && !dq_reg && (fq_reg == scmt_pkg::QK_NONE)))
        else $error("pending operator carries quote state");

endmodule

[hw/rtl/scmt_rec_fifo.sv]
module scmt_rec_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  scmt_pkg::rec_batch_t wr_batch,
    output logic                 space_ok,
    output logic                 m_valid,
    input  logic                 m_ready,
    output scmt_pkg::out_item_t  m_item
);

    localparam int PTR_W = scmt_pkg::FIFO_PTR_W;
    localparam int CNT_W = scmt_pkg::FIFO_CNT_W;

    scmt_pkg::out_item_t mem_reg [scmt_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [1:0]          wr_cnt;
    logic                rd_en;

    assign wr_cnt   = wr_en ? wr_batch.cnt : 2'd0;
    assign rd_en    = m_valid && m_ready;
    // room for a full batch of three
    assign space_ok = (count_reg <= CNT_W'(scmt_pkg::FIFO_DEPTH - scmt_pkg::REC_SLOTS));
    assign m_valid  = (count_reg != '0);
    assign m_item   = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(wr_cnt);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(rd_en);
    assign count_next  = count_reg + CNT_W'(wr_cnt) - CNT_W'(rd_en);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < scmt_pkg::REC_SLOTS; i++) begin
            if (2'(i) < wr_cnt) begin
                mem_reg[wr_ptr_reg + PTR_W'(i)] <= wr_batch.rec[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(scmt_pkg::FIFO_DEPTH))
        else $error("record buffer overflow");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != CNT_W'(scmt_pkg::FIFO_DEPTH))
        |-> (PTR_W'(count_reg) == PTR_W'(wr_ptr_reg - rd_ptr_reg)))
        else $error("pointers disagree with count");

    a_newest_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> mem_reg[wr_ptr_reg - PTR_W'(1)].run_last)
        else $error("newest record not closing its item");

endmodule

[hw/rtl/shell_command_tokenizer.sv]
// command-line tokenizer, one byte of the line per input item
// input channel s_*: item carries ch (never zero) and end_of_line, which
//   marks the last byte of a line
// result channel m_*: token records (kind, start_res, length, quote_kind);
//   run_last is set on the final record caused by one input byte
// a byte can cause zero to three records: words end on an unquoted space,
//   tab or operator, '<' and '>' wait one byte to see '<<' or '>>', and the
//   last byte of a line flushes any open token and adds an end-of-line record
// a byte's records are registered in the record buffer when the byte is taken
// throughput: one byte per cycle while each byte gives at most one record
//   and m_ready is high; a byte giving several records hands them out one at
//   a time through the single read port of the four-entry record buffer
// s_ready is high while at most one record waits, so bytes keep flowing when
//   the receiver takes records as they come
// when m_ready is low, records collect in the buffer and s_ready drops once
//   a further byte could overflow it; nothing is dropped
// reset (aresetn low, synchronous): lexer returns to idle at offset zero and
//   the record buffer empties
module shell_command_tokenizer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  scmt_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output scmt_pkg::out_item_t m_item
);

    logic                 s_accept;
    logic                 space_ok;
    scmt_pkg::rec_batch_t batch;

    // byte taken only when the buffer has room for a full batch
    assign s_ready  = space_ok;
    assign s_accept = s_valid && s_ready;

    // token state and per-byte record build
    scmt_lexer u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_en   (s_accept),
        .in_item (s_item),
        .batch   (batch)
    );

    // record buffer, doubles as the output register
    scmt_rec_fifo u_rec_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (s_accept),
        .wr_batch (batch),
        .space_ok (space_ok),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule
